@@ sv/smc_pkg.sv @@
// shared constants, codes and types for the stereo match confidence block
// no dependencies
package smc_pkg;

  localparam int WINDOW_DEF    = 7;
  localparam int MAX_DISP_DEF  = 64;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam int MAXD_W   = 7;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 2;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 10;
  localparam int CONF_W   = 8;

  localparam logic [MAXD_W-1:0]   MAXD_RST   = 7'd64;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd1024;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAX_DISP = 2'd0,
    CFG_COST_MODE = 2'd1,
    CFG_WIDTH = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } back_state_e;

endpackage

@@ sv/smc_queue.sv @@
// short job queue between the front and the back of the matcher
// depends on smc_pkg
module smc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);
  import smc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wp_q, rp_q;
  logic [NW-1:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(QUEUE_DEPTH));
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

@@ sv/smc_front.sv @@
// front end: accepts pixel pairs, keeps the raster position, fills the line stores
// and hands window jobs to the queue; depends on smc_pkg
module smc_front #(
  parameter int WINDOW    = smc_pkg::WINDOW_DEF,
  parameter int MAX_DISP  = smc_pkg::MAX_DISP_DEF,
  parameter int MAX_WIDTH = smc_pkg::MAX_WIDTH_DEF,
  localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CLW = $clog2(MAX_WIDTH),
  localparam int DW  = (MAX_DISP > 1) ? $clog2(MAX_DISP + 1) : 1,
  localparam int AW  = $clog2(WINDOW * MAX_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    left_pixel_i,
  input  logic [7:0]                    right_pixel_i,
  input  logic                          frame_start_i,
  input  logic [smc_pkg::MAXD_W-1:0]    max_disp_i,
  input  logic [smc_pkg::WIDTH_W-1:0]   width_i,
  input  logic [smc_pkg::HEIGHT_W-1:0]  height_i,
  input  logic                          pending_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output logic [smc_pkg::ROW_W-1:0]     job_row_o,
  output logic [CLW-1:0]                job_col_o,
  output logic [DW-1:0]                 job_dmax_o,
  output logic [SW-1:0]                 job_slot_o,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [7:0]                    wr_left_o,
  output logic [7:0]                    wr_right_o
);
  import smc_pkg::*;

  localparam int H   = WINDOW / 2;
  localparam int OFF = WINDOW - 2 * H;

  logic [ROW_W-1:0] row_q, row_d, last_row_q;
  logic [CLW-1:0]   col_q, col_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [ROW_W-1:0] cur_row;
  logic [CLW-1:0]   cur_col, lim;
  logic [SW-1:0]    cur_slot;
  logic [SW:0]      top;
  logic [12:0]      weff, heff, dsat;
  logic             safe, accept, emit, col_end, row_end;

  assign cur_row  = frame_start_i ? '0 : row_q;
  assign cur_col  = frame_start_i ? '0 : col_q;
  assign cur_slot = frame_start_i ? '0 : slot_q;

  // later writes may not touch rows still read by a queued job
  assign safe       = !pending_i || (!frame_start_i && row_q == last_row_q);
  assign in_stall_o = q_full_i || !safe;
  assign accept     = in_valid_i && !in_stall_o;

  assign emit = (13'(cur_row) >= 13'(2 * H)) && (13'(cur_col) >= 13'(2 * H));
  assign job_row_o = cur_row - ROW_W'(H);
  assign job_col_o = cur_col - CLW'(H);
  assign lim       = job_col_o - CLW'(H);

  always_comb begin
    dsat = (13'(max_disp_i) > 13'(MAX_DISP)) ? 13'(MAX_DISP) : 13'(max_disp_i);
    if (dsat > 13'(lim)) dsat = 13'(lim);
    top = (SW + 1)'(cur_slot) + (SW + 1)'(OFF);
    if (top >= (SW + 1)'(WINDOW)) top = top - (SW + 1)'(WINDOW);
  end
  assign job_dmax_o = DW'(dsat);
  assign job_slot_o = SW'(top);
  assign push_o     = accept && emit;

  assign wr_en_o    = accept;
  assign wr_addr_o  = AW'(cur_slot) * AW'(MAX_WIDTH) + AW'(cur_col);
  assign wr_left_o  = left_pixel_i;
  assign wr_right_o = right_pixel_i;

  assign weff = (width_i == '0) ? 13'd1 :
                (13'(width_i) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_i);
  assign heff = (height_i == '0) ? 13'd1 : 13'(height_i);
  assign col_end = (13'(cur_col) + 13'd1) >= weff;
  assign row_end = (13'(cur_row) + 13'd1) >= heff;

  always_comb begin
    row_d  = cur_row;
    col_d  = cur_col + 1'b1;
    slot_d = cur_slot;
    if (col_end) begin
      col_d = '0;
      if (row_end) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = cur_row + 1'b1;
        slot_d = (cur_slot == SW'(WINDOW - 1)) ? '0 : cur_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      slot_q     <= '0;
      last_row_q <= '0;
    end else if (accept) begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
      if (emit) last_row_q <= cur_row;
    end
  end
endmodule

@@ sv/smc_back.sv @@
// back end: line stores, window cost sequencer, best/second tracking,
// confidence divider and output register; depends on smc_pkg
module smc_back #(
  parameter int WINDOW    = smc_pkg::WINDOW_DEF,
  parameter int MAX_DISP  = smc_pkg::MAX_DISP_DEF,
  parameter int MAX_WIDTH = smc_pkg::MAX_WIDTH_DEF,
  localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CLW = $clog2(MAX_WIDTH),
  localparam int DW  = (MAX_DISP > 1) ? $clog2(MAX_DISP + 1) : 1,
  localparam int AW  = $clog2(WINDOW * MAX_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [7:0]                  wr_left_i,
  input  logic [7:0]                  wr_right_i,
  input  logic                        cost_mode_i,
  input  logic                        q_empty_i,
  output logic                        pop_o,
  input  logic [smc_pkg::ROW_W-1:0]   job_row_i,
  input  logic [CLW-1:0]              job_col_i,
  input  logic [DW-1:0]               job_dmax_i,
  input  logic [SW-1:0]               job_slot_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smc_pkg::CONF_W-1:0]  confidence_o,
  output logic [smc_pkg::ROW_W-1:0]   center_row_o,
  output logic [smc_pkg::OCOL_W-1:0]  center_col_o
);
  import smc_pkg::*;

  localparam int H     = WINDOW / 2;
  localparam int DEPTH = WINDOW * MAX_WIDTH;
  localparam int CW    = $clog2(WINDOW * WINDOW * 65025 + 1);

  back_state_e state_q, state_d;

  logic [7:0] left_mem [DEPTH];
  logic [7:0] right_mem [DEPTH];

  logic [ROW_W-1:0] jrow_q;
  logic [CLW-1:0]   jcol_q;
  logic [DW-1:0]    jdmax_q, d_q;
  logic [SW-1:0]    i_q, j_q, rs_q, jslot_q;

  logic             issue, load_out, last_win, last_job;
  logic [12:0]      col_l, col_r;
  logic [AW-1:0]    base, addr_l, addr_r;

  logic             v1_q, lw1_q, lj1_q, f1_q, s1_q;
  logic [7:0]       rl_q, rr_q;
  logic             v2_q, lw2_q, lj2_q, f2_q, s2_q;
  logic [15:0]      t2_q;
  logic [8:0]       diff;
  logic [7:0]       mag;
  logic [CW-1:0]    acc_q, cost, best_q, second_q;

  logic [CW+7:0]    rem_q;
  logic [CW:0]      dsr_q;
  logic [2:0]       k_q;
  logic [7:0]       quo_q;
  logic [CW+8:0]    shifted;
  logic [CW-1:0]    gap;

  logic             ov_q;
  logic [CONF_W-1:0] conf_q;
  logic [ROW_W-1:0] orow_q;
  logic [OCOL_W-1:0] ocol_q;

  // line stores: one write from the front, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      left_mem[wr_addr_i]  <= wr_left_i;
      right_mem[wr_addr_i] <= wr_right_i;
    end
    rl_q <= left_mem[addr_l];
    rr_q <= right_mem[addr_r];
  end

  assign col_l  = 13'(jcol_q) + 13'(j_q) - 13'(H);
  assign col_r  = col_l - 13'(d_q);
  assign base   = AW'(rs_q) * AW'(MAX_WIDTH);
  assign addr_l = base + AW'(col_l[CLW-1:0]);
  assign addr_r = base + AW'(col_r[CLW-1:0]);

  assign last_win = (i_q == SW'(WINDOW - 1)) && (j_q == SW'(WINDOW - 1));
  assign last_job = last_win && (d_q == jdmax_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!q_empty_i) state_d = ST_RUN;
      ST_RUN:   if (last_job) state_d = ST_DRAIN;
      ST_DRAIN: if (v2_q && lj2_q) state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV:   if (k_q == 3'd0) state_d = ST_DONE;
      ST_DONE:  if (!ov_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    busy_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        pop_o  = !q_empty_i;
      end
      ST_RUN:  issue = 1'b1;
      ST_DONE: load_out = !ov_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // sequencer counters and job fields
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      jrow_q  <= job_row_i;
      jcol_q  <= job_col_i;
      jdmax_q <= job_dmax_i;
      jslot_q <= job_slot_i;
      rs_q    <= job_slot_i;
      d_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else if (issue) begin
      if (j_q == SW'(WINDOW - 1)) begin
        j_q <= '0;
        if (i_q == SW'(WINDOW - 1)) begin
          i_q  <= '0;
          rs_q <= jslot_q;
          d_q  <= d_q + 1'b1;
        end else begin
          i_q  <= i_q + 1'b1;
          rs_q <= (rs_q == SW'(WINDOW - 1)) ? '0 : rs_q + 1'b1;
        end
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  // pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  assign diff = {1'b0, rl_q} - {1'b0, rr_q};
  assign mag  = diff[8] ? 8'(-diff) : diff[7:0];

  always_ff @(posedge clk_i) begin
    lw1_q <= last_win;
    lj1_q <= last_job;
    f1_q  <= (d_q == '0);
    s1_q  <= (d_q == DW'(1));
    lw2_q <= lw1_q;
    lj2_q <= lj1_q;
    f2_q  <= f1_q;
    s2_q  <= s1_q;
    t2_q  <= cost_mode_i ? (16'(mag) * 16'(mag)) : 16'(mag);
  end

  // window accumulation and best / second-best tracking
  assign cost = acc_q + CW'(t2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      best_q   <= '0;
      second_q <= '0;
    end else if (pop_o) begin
      acc_q <= '0;
    end else if (v2_q) begin
      if (lw2_q) begin
        acc_q <= '0;
        if (f2_q) begin
          best_q <= cost;
        end else if (s2_q) begin
          if (cost < best_q) begin
            second_q <= best_q;
            best_q   <= cost;
          end else begin
            second_q <= cost;
          end
        end else if (cost < best_q) begin
          second_q <= best_q;
          best_q   <= cost;
        end else if (cost < second_q) begin
          second_q <= cost;
        end
      end else begin
        acc_q <= cost;
      end
    end
  end

  // restoring divider, one quotient bit per cycle; quotient below 255 whenever dmax is nonzero
  assign gap     = second_q - best_q;
  assign shifted = (CW + 9)'(dsr_q) << k_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      rem_q <= {gap, 8'd0} - (CW + 8)'(gap);
      dsr_q <= (CW + 1)'(second_q) + 1'b1;
      k_q   <= 3'd7;
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      if ((CW + 9)'(rem_q) >= shifted) begin
        rem_q        <= rem_q - (CW + 8)'(shifted);
        quo_q[k_q]   <= 1'b1;
      end
      k_q <= k_q - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (load_out) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      conf_q <= (jdmax_q == '0) ? '0 : quo_q;
      orow_q <= jrow_q;
      ocol_q <= OCOL_W'(jcol_q);
    end
  end

  assign out_valid_o  = ov_q;
  assign confidence_o = conf_q;
  assign center_row_o = orow_q;
  assign center_col_o = ocol_q;
endmodule

@@ sv/stereo_match_confidence.sv @@
// stereo match confidence: a pixel that completes a window gives its result, and a pixel
// that completes none gives none; the back end reads one window pixel per cycle from each
// line store for every cost of a job, then fetch, drain, prep, 8 divider steps and the output
// register follow; input stalls while the job queue is full or a queued job still reads rows
// about to change; reset clears position counters, config registers and handshake state, not
// the line stores
module stereo_match_confidence #(
  parameter int WINDOW    = smc_pkg::WINDOW_DEF,
  parameter int MAX_DISP  = smc_pkg::MAX_DISP_DEF,
  parameter int MAX_WIDTH = smc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smc_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [smc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  left_pixel_i,
  input  logic [7:0]                  right_pixel_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smc_pkg::CONF_W-1:0]  confidence_o,
  output logic [smc_pkg::ROW_W-1:0]   center_row_o,
  output logic [smc_pkg::OCOL_W-1:0]  center_col_o
);
  import smc_pkg::*;

  localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int DW  = (MAX_DISP > 1) ? $clog2(MAX_DISP + 1) : 1;
  localparam int AW  = $clog2(WINDOW * MAX_WIDTH);
  localparam int QW  = ROW_W + CLW + DW + SW;

  // configuration registers
  logic [MAXD_W-1:0]   max_disp_q;
  logic                cost_mode_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_disp_q  <= MAXD_RST;
      cost_mode_q <= 1'b0;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_DISP:  max_disp_q  <= cfg_data_i[MAXD_W-1:0];
        CFG_COST_MODE: cost_mode_q <= cfg_data_i[0];
        CFG_WIDTH:     width_q     <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT:    height_q    <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // front to back wiring
  logic             push, pop, q_empty, q_full, busy, pending;
  logic [ROW_W-1:0] f_row, b_row;
  logic [CLW-1:0]   f_col, b_col;
  logic [DW-1:0]    f_dmax, b_dmax;
  logic [SW-1:0]    f_slot, b_slot;
  logic [QW-1:0]    q_in, q_out;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_left, wr_right;

  // anything still reading the line stores blocks writes into other rows
  assign pending = busy || !q_empty;

  smc_front #(
    .WINDOW(WINDOW), .MAX_DISP(MAX_DISP), .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .left_pixel_i, .right_pixel_i, .frame_start_i,
    .max_disp_i (max_disp_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .pending_i  (pending),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_row_o  (f_row),
    .job_col_o  (f_col),
    .job_dmax_o (f_dmax),
    .job_slot_o (f_slot),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_left_o  (wr_left),
    .wr_right_o (wr_right)
  );

  assign q_in = {f_row, f_col, f_dmax, f_slot};
  assign {b_row, b_col, b_dmax, b_slot} = q_out;

  smc_queue #(.DATA_W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  smc_back #(
    .WINDOW(WINDOW), .MAX_DISP(MAX_DISP), .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_left_i   (wr_left),
    .wr_right_i  (wr_right),
    .cost_mode_i (cost_mode_q),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .job_row_i   (b_row),
    .job_col_i   (b_col),
    .job_dmax_i  (b_dmax),
    .job_slot_i  (b_slot),
    .busy_o      (busy),
    .out_valid_o, .out_stall_i,
    .confidence_o, .center_row_o, .center_col_o
  );

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");

  a_pop_starts_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> busy)
    else $error("back end idle after taking a job");

  a_frame_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && frame_start_i |-> !pending)
    else $error("frame start taken while line stores are still read");
endmodule
